// File: rtl/arq_retransmit_window_defines.svh
// ----------------------------------------------------------------------------
// ARQ retransmit window assertion macros
// Shared concurrent assertion shorthands, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ARQ_RETRANSMIT_WINDOW_DEFINES_SVH
`define ARQ_RETRANSMIT_WINDOW_DEFINES_SVH

// Same-cycle implication.
`define ARQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arq window check failed");

// Next-cycle implication.
`define ARQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arq window check failed");

`endif

// File: rtl/arq_pkg.sv
// ----------------------------------------------------------------------------
// ARQ window package
// Shared constants, register indexes, request codes and the sequencer states.
// ----------------------------------------------------------------------------
package arq_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 16;
    localparam int DEFAULT_HANDLE_BITS  = 16;

    localparam int SEQ_W   = 32;
    localparam int TIME_W  = 32;
    localparam int TO_W    = 16;
    localparam int RETRY_W = 8;
    localparam int WL_W    = 5;
    localparam int OCC_W   = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [TO_W-1:0] TIMEOUT_CAP = 16'd500;

    localparam logic [WL_W-1:0]    RST_WINDOW_LIMIT    = 5'd8;
    localparam logic [TO_W-1:0]    RST_INITIAL_TIMEOUT = 16'd100;
    localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT     = 8'd3;

    localparam logic [1:0] REG_WINDOW_LIMIT    = 2'd0;
    localparam logic [1:0] REG_INITIAL_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT     = 2'd2;

    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_POLL = 2'd2;

    localparam logic RESULT_STATUS = 1'b0;
    localparam logic RESULT_RETX   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_INSERT,
        ST_PROC_RD,
        ST_PROC_CHK,
        ST_EMIT_RTX,
        ST_EMIT_STAT
    } state_t;

endpackage

// File: rtl/arq_ram.sv
// ----------------------------------------------------------------------------
// ARQ generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/arq_retransmit_window.sv
// Send and ack scan the window slot by slot, reading each valid slot and skipping
//   empty ones; a new send then inserts the frame, and both emit a status result.
// Poll: one ordering scan per valid slot plus one final scan; each visited
//   slot is read again, checked and may emit a retransmit result.
// Throughput is set by the single read port of the slot RAM; one item at a time.
// Reset: all slots empty, counters zero, registers at their defaults.
// ----------------------------------------------------------------------------
// ARQ retransmit window
// Selective-repeat window of outstanding frames kept in a slot RAM, with
// valid bits in flops, a scan sequencer and an APB register port.
// ----------------------------------------------------------------------------
`include "arq_retransmit_window_defines.svh"

module arq_retransmit_window #(
    parameter int WINDOW_DEPTH = arq_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int HANDLE_BITS  = arq_pkg::DEFAULT_HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [arq_pkg::SEQ_W-1:0]     seq_num,
    input  logic [HANDLE_BITS-1:0]        frame_handle,
    input  logic [arq_pkg::TIME_W-1:0]    now_ms,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic [arq_pkg::SEQ_W-1:0]     out_seq,
    output logic [HANDLE_BITS-1:0]        out_handle,
    output logic                          accepted,
    output logic [arq_pkg::OCC_W-1:0]     occupancy,
    output logic                          window_full,
    output logic [31:0]                   acked_total,
    output logic [31:0]                   dropped_total,
    output logic [31:0]                   retransmit_total,
    output logic                          last,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arq_pkg::PADDR_W-1:0]   paddr,
    input  logic [arq_pkg::PDATA_W-1:0]   pwdata,
    output logic [arq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int D   = WINDOW_DEPTH;
    localparam int IW  = (D > 1) ? $clog2(D) : 1;
    localparam int OW  = $clog2(D + 1);
    localparam int CW  = (OW > arq_pkg::WL_W) ? OW : arq_pkg::WL_W;
    localparam int HB  = HANDLE_BITS;

    // Slot entry layout: {seq, handle, retries, timeout, deadline}
    localparam int DL_LSB  = 0;
    localparam int TO_LSB  = DL_LSB + arq_pkg::TIME_W;
    localparam int RT_LSB  = TO_LSB + arq_pkg::TO_W;
    localparam int HD_LSB  = RT_LSB + arq_pkg::RETRY_W;
    localparam int SQ_LSB  = HD_LSB + HB;
    localparam int ENTRY_W = SQ_LSB + arq_pkg::SEQ_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(D - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(D);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [arq_pkg::WL_W-1:0]    window_limit_reg;
    logic [arq_pkg::TO_W-1:0]    init_to_reg;
    logic [arq_pkg::RETRY_W-1:0] retry_limit_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= arq_pkg::RST_WINDOW_LIMIT;
            init_to_reg      <= arq_pkg::RST_INITIAL_TIMEOUT;
            retry_limit_reg  <= arq_pkg::RST_RETRY_LIMIT;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                arq_pkg::REG_WINDOW_LIMIT:    window_limit_reg <= pwdata[arq_pkg::WL_W-1:0];
                arq_pkg::REG_INITIAL_TIMEOUT: init_to_reg      <= pwdata[arq_pkg::TO_W-1:0];
                arq_pkg::REG_RETRY_LIMIT:     retry_limit_reg  <= pwdata[arq_pkg::RETRY_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            arq_pkg::REG_WINDOW_LIMIT:    prdata = 32'(window_limit_reg);
            arq_pkg::REG_INITIAL_TIMEOUT: prdata = 32'(init_to_reg);
            arq_pkg::REG_RETRY_LIMIT:     prdata = 32'(retry_limit_reg);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Slot RAM
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    arq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (D),
        .AW    (IW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [arq_pkg::SEQ_W-1:0]   rd_seq;
    logic [HB-1:0]               rd_handle;
    logic [arq_pkg::RETRY_W-1:0] rd_retries;
    logic [arq_pkg::TO_W-1:0]    rd_timeout;
    logic [arq_pkg::TIME_W-1:0]  rd_deadline;

    assign rd_seq      = ram_rdata[SQ_LSB +: arq_pkg::SEQ_W];
    assign rd_handle   = ram_rdata[HD_LSB +: HB];
    assign rd_retries  = ram_rdata[RT_LSB +: arq_pkg::RETRY_W];
    assign rd_timeout  = ram_rdata[TO_LSB +: arq_pkg::TO_W];
    assign rd_deadline = ram_rdata[DL_LSB +: arq_pkg::TIME_W];

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    arq_pkg::state_t             state_reg, state_next;
    logic [1:0]                  req_reg, req_next;
    logic [arq_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [HB-1:0]               handle_reg, handle_next;
    logic [arq_pkg::TIME_W-1:0]  now_reg, now_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [D-1:0]                valid_reg, valid_next;
    logic [D-1:0]                done_reg, done_next;
    logic                        best_vld_reg, best_vld_next;
    logic [IW-1:0]               best_idx_reg, best_idx_next;
    logic [arq_pkg::SEQ_W-1:0]   best_seq_reg, best_seq_next;
    logic [HB-1:0]               rtx_handle_reg, rtx_handle_next;
    logic                        acc_reg, acc_next;
    logic [OW-1:0]               occ_reg, occ_next;
    logic [31:0]                 ack_cnt_reg, ack_cnt_next;
    logic [31:0]                 drop_cnt_reg, drop_cnt_next;
    logic [31:0]                 resend_cnt_reg, resend_cnt_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic                        out_kind_reg, out_kind_next;
    logic [arq_pkg::SEQ_W-1:0]   out_seq_reg, out_seq_next;
    logic [HB-1:0]               out_handle_reg, out_handle_next;
    logic                        out_acc_reg, out_acc_next;
    logic [arq_pkg::OCC_W-1:0]   out_occ_reg, out_occ_next;
    logic                        out_full_reg, out_full_next;
    logic [31:0]                 out_ack_reg, out_ack_next;
    logic [31:0]                 out_drop_reg, out_drop_next;
    logic [31:0]                 out_resend_reg, out_resend_next;
    logic                        out_last_reg, out_last_next;

    // Helpers
    logic [CW-1:0]               wl_ext;
    logic [CW-1:0]               eff_limit;
    logic [CW-1:0]               occ_ext;
    logic                        out_free;
    logic                        last_idx;
    logic [IW-1:0]               free_idx;
    logic [arq_pkg::TIME_W:0]    ins_sum;
    logic [arq_pkg::TIME_W-1:0]  ins_deadline;
    logic [arq_pkg::TO_W:0]      grow;
    logic [arq_pkg::TO_W-1:0]    new_to;
    logic [arq_pkg::TIME_W:0]    re_sum;
    logic [arq_pkg::TIME_W-1:0]  re_deadline;

    assign wl_ext    = CW'(window_limit_reg);
    assign eff_limit = (wl_ext > DEPTH_C) ? DEPTH_C : wl_ext;
    assign occ_ext   = CW'(occ_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign last_idx  = (idx_reg == LAST_IDX);
    assign in_ready  = (state_reg == arq_pkg::ST_IDLE);

    // Lowest empty slot for an insert.
    always_comb
    begin
        free_idx = '0;
        for (int i = D - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    // Deadline for a new frame, saturating.
    assign ins_sum      = {1'b0, now_reg} + (arq_pkg::TIME_W + 1)'(init_to_reg);
    assign ins_deadline = ins_sum[arq_pkg::TIME_W] ? '1 : ins_sum[arq_pkg::TIME_W-1:0];

    // Timeout growth: t + t/2, capped.
    assign grow   = {1'b0, rd_timeout} + {2'b00, rd_timeout[arq_pkg::TO_W-1:1]};
    assign new_to = (grow > (arq_pkg::TO_W + 1)'(arq_pkg::TIMEOUT_CAP))
                    ? arq_pkg::TIMEOUT_CAP : grow[arq_pkg::TO_W-1:0];
    assign re_sum      = {1'b0, now_reg} + (arq_pkg::TIME_W + 1)'(new_to);
    assign re_deadline = re_sum[arq_pkg::TIME_W] ? '1 : re_sum[arq_pkg::TIME_W-1:0];

    always_comb
    begin
        logic scan_done;

        state_next      = state_reg;
        req_next        = req_reg;
        seq_next        = seq_reg;
        handle_next     = handle_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        done_next       = done_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_seq_next   = best_seq_reg;
        rtx_handle_next = rtx_handle_reg;
        acc_next        = acc_reg;
        occ_next        = occ_reg;
        ack_cnt_next    = ack_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        resend_cnt_next = resend_cnt_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_handle_next = out_handle_reg;
        out_acc_next    = out_acc_reg;
        out_occ_next    = out_occ_reg;
        out_full_next   = out_full_reg;
        out_ack_next    = out_ack_reg;
        out_drop_next   = out_drop_reg;
        out_resend_next = out_resend_reg;
        out_last_next   = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata = {seq_reg, handle_reg, {arq_pkg::RETRY_W{1'b0}}, init_to_reg, ins_deadline};
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        scan_done = 1'b0;

        unique case (state_reg)
            arq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_type;
                    seq_next      = seq_num;
                    handle_next   = frame_handle;
                    now_next      = now_ms;
                    idx_next      = '0;
                    acc_next      = 1'b0;
                    best_vld_next = 1'b0;
                    done_next     = '0;
                    unique case (req_type)
                        arq_pkg::REQ_SEND:
                        begin
                            if (occ_ext < eff_limit)
                            begin
                                acc_next   = 1'b1;
                                state_next = arq_pkg::ST_SCAN_RD;
                            end
                            else
                            begin
                                state_next = arq_pkg::ST_EMIT_STAT;
                            end
                        end
                        arq_pkg::REQ_ACK,
                        arq_pkg::REQ_POLL:
                        begin
                            state_next = arq_pkg::ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = arq_pkg::ST_EMIT_STAT;
                        end
                    endcase
                end
            end

            arq_pkg::ST_SCAN_RD:
            begin
                // Read occupied slots; skip empty ones and, on a poll, visited ones.
                if (valid_reg[idx_reg] && !(req_reg == arq_pkg::REQ_POLL && done_reg[idx_reg]))
                begin
                    ram_re     = 1'b1;
                    state_next = arq_pkg::ST_SCAN_CHK;
                end
                else if (last_idx)
                begin
                    scan_done = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            arq_pkg::ST_SCAN_CHK:
            begin
                if (req_reg == arq_pkg::REQ_SEND && rd_seq == seq_reg)
                begin
                    // Duplicate: accept, change nothing.
                    state_next = arq_pkg::ST_EMIT_STAT;
                end
                else if (req_reg == arq_pkg::REQ_ACK && rd_seq == seq_reg)
                begin
                    valid_next[idx_reg] = 1'b0;
                    occ_next            = occ_reg - 1'b1;
                    ack_cnt_next        = ack_cnt_reg + 32'd1;
                    acc_next            = 1'b1;
                    state_next          = arq_pkg::ST_EMIT_STAT;
                end
                else
                begin
                    if (req_reg == arq_pkg::REQ_POLL && (!best_vld_reg || rd_seq < best_seq_reg))
                    begin
                        best_vld_next = 1'b1;
                        best_idx_next = idx_reg;
                        best_seq_next = rd_seq;
                    end
                    if (last_idx)
                    begin
                        scan_done = 1'b1;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = arq_pkg::ST_SCAN_RD;
                    end
                end
            end

            arq_pkg::ST_INSERT:
            begin
                ram_we               = 1'b1;
                valid_next[free_idx] = 1'b1;
                occ_next             = occ_reg + 1'b1;
                state_next           = arq_pkg::ST_EMIT_STAT;
            end

            arq_pkg::ST_PROC_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = best_idx_reg;
                state_next = arq_pkg::ST_PROC_CHK;
            end

            arq_pkg::ST_PROC_CHK:
            begin
                // Restart the ordering scan for the next-lowest sequence.
                idx_next      = '0;
                best_vld_next = 1'b0;
                state_next    = arq_pkg::ST_SCAN_RD;
                if (now_reg < rd_deadline)
                begin
                    state_next = arq_pkg::ST_SCAN_RD;
                end
                else if (rd_retries >= retry_limit_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    occ_next                 = occ_reg - 1'b1;
                    drop_cnt_next            = drop_cnt_reg + 32'd1;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = best_idx_reg;
                    ram_wdata       = {rd_seq, rd_handle, rd_retries + 1'b1, new_to,
                                       re_deadline};
                    resend_cnt_next = resend_cnt_reg + 32'd1;
                    rtx_handle_next = rd_handle;
                    state_next      = arq_pkg::ST_EMIT_RTX;
                end
            end

            arq_pkg::ST_EMIT_RTX:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = arq_pkg::RESULT_RETX;
                    out_seq_next    = best_seq_reg;
                    out_handle_next = rtx_handle_reg;
                    out_acc_next    = 1'b0;
                    out_occ_next    = '0;
                    out_full_next   = 1'b0;
                    out_ack_next    = '0;
                    out_drop_next   = '0;
                    out_resend_next = '0;
                    out_last_next   = 1'b0;
                    state_next      = arq_pkg::ST_SCAN_RD;
                end
            end

            arq_pkg::ST_EMIT_STAT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = arq_pkg::RESULT_STATUS;
                    out_seq_next    = '0;
                    out_handle_next = '0;
                    out_acc_next    = acc_reg;
                    out_occ_next    = occ_ext[arq_pkg::OCC_W-1:0];
                    out_full_next   = (occ_ext >= eff_limit);
                    out_ack_next    = ack_cnt_reg;
                    out_drop_next   = drop_cnt_reg;
                    out_resend_next = resend_cnt_reg;
                    out_last_next   = 1'b1;
                    state_next      = arq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = arq_pkg::ST_IDLE;
            end
        endcase

        // End of a full pass over the window.
        if (scan_done)
        begin
            unique case (req_reg)
                arq_pkg::REQ_SEND:
                begin
                    state_next = arq_pkg::ST_INSERT;
                end
                arq_pkg::REQ_POLL:
                begin
                    if (best_vld_next)
                    begin
                        done_next[best_idx_next] = 1'b1;
                        state_next               = arq_pkg::ST_PROC_RD;
                    end
                    else
                    begin
                        state_next = arq_pkg::ST_EMIT_STAT;
                    end
                end
                default:
                begin
                    state_next = arq_pkg::ST_EMIT_STAT;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= arq_pkg::ST_IDLE;
            valid_reg      <= '0;
            done_reg       <= '0;
            best_vld_reg   <= 1'b0;
            occ_reg        <= '0;
            ack_cnt_reg    <= '0;
            drop_cnt_reg   <= '0;
            resend_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            req_reg        <= '0;
            acc_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            best_vld_reg   <= best_vld_next;
            occ_reg        <= occ_next;
            ack_cnt_reg    <= ack_cnt_next;
            drop_cnt_reg   <= drop_cnt_next;
            resend_cnt_reg <= resend_cnt_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            req_reg        <= req_next;
            acc_reg        <= acc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        seq_reg         <= seq_next;
        handle_reg      <= handle_next;
        now_reg         <= now_next;
        best_idx_reg    <= best_idx_next;
        best_seq_reg    <= best_seq_next;
        rtx_handle_reg  <= rtx_handle_next;
        out_kind_reg    <= out_kind_next;
        out_seq_reg     <= out_seq_next;
        out_handle_reg  <= out_handle_next;
        out_acc_reg     <= out_acc_next;
        out_occ_reg     <= out_occ_next;
        out_full_reg    <= out_full_next;
        out_ack_reg     <= out_ack_next;
        out_drop_reg    <= out_drop_next;
        out_resend_reg  <= out_resend_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign out_seq          = out_seq_reg;
    assign out_handle       = out_handle_reg;
    assign accepted         = out_acc_reg;
    assign occupancy        = out_occ_reg;
    assign window_full      = out_full_reg;
    assign acked_total      = out_ack_reg;
    assign dropped_total    = out_drop_reg;
    assign retransmit_total = out_resend_reg;
    assign last             = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Occupancy counter tracks the valid bits.
    `ARQ_ASSERT_NOW(a_occ_matches_valid, 1'b1, (32'(occ_reg) == 32'($countones(valid_reg))))
    // Every slot written is occupied afterwards.
    `ARQ_ASSERT_NEXT(a_write_leaves_valid, ram_we, valid_reg[$past(ram_waddr)])
    // A retransmit result never closes an item.
    `ARQ_ASSERT_NOW(a_retx_not_last, out_valid && result_kind == arq_pkg::RESULT_RETX, !last)

endmodule
